FILE: sv/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared constants and types for the percentile spread block
// Widths, count cap, register indexes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package hps_pkg;

  // histogram geometry
  localparam int NUM_LEVELS = 256;
  localparam int LEVEL_W    = 8;
  localparam int COUNT_W    = 11;
  localparam int RANK_W     = 11;
  // cumulative sum of all levels at the largest count
  localparam int CUM_W      = 19;

  // per-level count saturates at the smaller of the row limit and the 11-bit max
  localparam int MAX_ROWS      = 1024;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP     = (MAX_ROWS < COUNT_MAX) ? MAX_ROWS : COUNT_MAX;

  // configuration registers
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_MEDIAN_RANK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_RANK  = 1'b1;
  localparam logic [RANK_W-1:0] MEDIAN_RANK_RST = 11'd500;
  localparam logic [RANK_W-1:0] UPPER_RANK_RST  = 11'd800;

  localparam int OUT_W = 3 * LEVEL_W;

  // controller -> datapath
  typedef struct packed {
    logic               take;      // sample beat accepted, start its count update
    logic               scan_rd;   // issue a histogram read for the scan
    logic [LEVEL_W-1:0] scan_idx;  // level read by the scan
    logic               load_out;  // move the found levels into the result register
    logic               clear;     // drop the histogram and scan state
  } hps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;                // result register holds a beat not yet taken
  } hps_stat_t;

endpackage

FILE: sv/hps_ctrl.sv
// ----------------------------------------------------------------------------
// hps_ctrl: sequencer for the percentile spread block
// Takes samples, then runs the 256-level scan and hands the result over.
// ----------------------------------------------------------------------------
module hps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  hps_pkg::hps_stat_t stat,
  output hps_pkg::hps_cmd_t  cmd
);
  import hps_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN,    // counting samples
    ST_FLUSH,  // last sample's count write lands
    ST_SCAN,   // one level read per cycle
    ST_TAIL,   // last level accumulates
    ST_DONE    // wait for a free result register
  } state_t;

  state_t             state;
  logic [LEVEL_W-1:0] scan_idx;
  logic               take;

  assign take = s_tvalid && s_tready;

  // command decode
  always_comb begin
    s_tready      = (state == ST_RUN);
    cmd.take      = take;
    cmd.scan_rd   = (state == ST_SCAN);
    cmd.scan_idx  = scan_idx;
    cmd.load_out  = (state == ST_DONE) && !stat.out_busy;
    cmd.clear     = (state == ST_DONE) && !stat.out_busy;
  end

  // state and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      scan_idx <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (take && s_tlast) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          scan_idx <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + LEVEL_W'(1);
          if (scan_idx == LEVEL_W'(NUM_LEVELS - 1)) state <= ST_TAIL;
        end
        ST_TAIL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!stat.out_busy) state <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

FILE: sv/hps_datapath.sv
// ----------------------------------------------------------------------------
// hps_datapath: histogram memory, count update, cumulative scan, result
// One read and one write port; counts forward across back-to-back updates.
// ----------------------------------------------------------------------------
module hps_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hps_pkg::LEVEL_W-1:0]          sample,
  input  logic                                 cfg_we,
  input  logic [hps_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [hps_pkg::RANK_W-1:0]           cfg_data,
  input  hps_pkg::hps_cmd_t                    cmd,
  output hps_pkg::hps_stat_t                   stat,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [hps_pkg::OUT_W-1:0]            m_tdata
);
  import hps_pkg::*;

  // histogram storage; an entry without its valid bit reads as zero
  logic [COUNT_W-1:0]    cnt_mem [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] vld;

  logic [RANK_W-1:0]  median_rank;
  logic [RANK_W-1:0]  upper_rank;

  logic [LEVEL_W-1:0] rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               rd_hit;
  logic [COUNT_W-1:0] rd_count;

  logic               upd_en;
  logic [LEVEL_W-1:0] upd_addr;
  logic               wr_en_q;
  logic [LEVEL_W-1:0] wr_addr_q;
  logic [COUNT_W-1:0] wr_val_q;
  logic [COUNT_W-1:0] upd_base;
  logic [COUNT_W-1:0] upd_val;

  logic               acc_en;
  logic [LEVEL_W-1:0] acc_level;
  logic [CUM_W-1:0]   cum;
  logic [CUM_W-1:0]   cum_next;
  logic               med_found;
  logic               upp_found;
  logic [LEVEL_W-1:0] med;
  logic [LEVEL_W-1:0] upp;
  logic [LEVEL_W-1:0] spread;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      median_rank <= MEDIAN_RANK_RST;
      upper_rank  <= UPPER_RANK_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MEDIAN_RANK: median_rank <= cfg_data;
        REG_UPPER_RANK:  upper_rank  <= cfg_data;
        default: ;
      endcase
    end
  end

  // read port: sample level while counting, scan index while scanning
  assign rd_addr  = cmd.scan_rd ? cmd.scan_idx : sample;
  assign rd_count = rd_hit ? rd_data : '0;

  always_ff @(posedge clk) begin
    rd_data <= cnt_mem[rd_addr];
  end

  // count update, forwarding the previous write when it hits the same level
  assign upd_base = (wr_en_q && (wr_addr_q == upd_addr)) ? wr_val_q : rd_count;
  assign upd_val  = (upd_base < COUNT_W'(COUNT_CAP)) ? upd_base + COUNT_W'(1) : upd_base;

  always_ff @(posedge clk) begin
    if (upd_en) cnt_mem[upd_addr] <= upd_val;
  end

  always_ff @(posedge clk) begin
    upd_addr  <= sample;
    wr_addr_q <= upd_addr;
    wr_val_q  <= upd_val;
    acc_level <= cmd.scan_idx;
  end

  // valid bits and pipeline controls
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_hit  <= 1'b0;
      upd_en  <= 1'b0;
      wr_en_q <= 1'b0;
      acc_en  <= 1'b0;
    end else begin
      rd_hit  <= vld[rd_addr];
      upd_en  <= cmd.take;
      wr_en_q <= upd_en;
      acc_en  <= cmd.scan_rd;
      if (cmd.clear)   vld <= '0;
      else if (upd_en) vld[upd_addr] <= 1'b1;
    end
  end

  // cumulative scan: first level whose running sum reaches each rank
  assign cum_next = cum + CUM_W'(rd_count);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cum       <= '0;
      med_found <= 1'b0;
      upp_found <= 1'b0;
      med       <= '0;
      upp       <= '0;
    end else if (acc_en) begin
      cum <= cum_next;
      if (!med_found && (cum_next >= CUM_W'(median_rank))) begin
        med_found <= 1'b1;
        med       <= acc_level;
      end
      if (!upp_found && (cum_next >= CUM_W'(upper_rank))) begin
        upp_found <= 1'b1;
        upp       <= acc_level;
      end
    end
  end

  assign spread = (upp > med) ? (upp - med) : '0;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) m_tdata <= {spread, upp, med};
  end

  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

FILE: sv/histogram_percentile_spread_top.sv
// ----------------------------------------------------------------------------
// histogram_percentile_spread_top: median / upper percentile level spread
// Builds a 256-level histogram of one window and reports two levels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one 8-bit sample per beat, s_tlast on the window's
//   last sample. Samples are taken one per cycle while a window fills.
//   Output channel m_*: one beat per window with the median level, the
//   upper level and their difference clamped at zero.
//   cfg_*: write median_rank (index 0) or upper_rank (index 1) while idle.
// Timing:
//   After the last beat of a window the histogram is scanned, one level
//   per cycle from its single read port, and the input is held off until
//   the result is loaded into the output register.
// Reset:
//   rst clears the histogram and loads the rank defaults 500 and 800.
// Stall:
//   A result waits in the output register; samples of the next window keep
//   flowing meanwhile, and only the next scan's hand-over waits for it.
// ----------------------------------------------------------------------------
module histogram_percentile_spread_top (
  input  logic                              clk,
  input  logic                              rst,
  // sample beats
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] sample
  input  logic                              s_tlast,   // window_end
  // result beats
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,   // [7:0] median_level,
                                                       // [15:8] upper_level,
                                                       // [23:16] spread
  // configuration writes
  input  logic                              cfg_we,
  input  logic [hps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hps_pkg::RANK_W-1:0]        cfg_data
);
  import hps_pkg::*;

  hps_cmd_t  cmd;
  hps_stat_t stat;

  hps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .sample   (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
